FILE: hdl/prl_pkg.sv
// Shared types and constants for the partition refinement labeler.
`timescale 1ns / 1ps
`default_nettype none

package prl_pkg;

    localparam int LABEL_W     = 6;
    localparam int SLOT_W      = 2 * LABEL_W;
    localparam int TABLE_DEPTH = 1 << SLOT_W;
    localparam int TOTAL_W     = 7;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = 3;

    typedef logic [LABEL_W-1:0] t_label;
    typedef logic [SLOT_W-1:0]  t_slot;

    typedef struct packed {
        t_label               new_label;
        logic [TOTAL_W-1:0]   group_total;
        logic                 end_mark;
    } t_result;

    typedef struct packed {
        logic       clearing;
        logic [1:0] inflight;
    } t_core_stat;

endpackage

`default_nettype wire

FILE: hdl/prl_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module prl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/prl_fifo.sv
// Four-entry result queue between the lookup pipeline and the output stream.
`timescale 1ns / 1ps
`default_nettype none

module prl_fifo
    import prl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire t_result           i_data,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output t_result                o_data,
    output logic [QCNT_W-1:0]      o_count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_result            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]  r_count;
    logic               pop_ok;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(pop_ok);
        end
    end

endmodule

`default_nettype wire

FILE: hdl/prl_core.sv
// Lookup pipeline: pair table, group key table, forwarding and group counter.
`timescale 1ns / 1ps
`default_nettype none

module prl_core
    import prl_pkg::*;
#(
    parameter int MAX_ROWS = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_slot  i_slot,
    input  wire logic   i_last,
    output logic        o_res_valid,
    output t_result     o_res,
    output t_core_stat  o_stat
);

    localparam int GW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);

    // Pair table holds the group handed to a slot; the key table holds the
    // slot that owns each group. A slot is seen in this partition only when
    // its group is below the counter and that group's key points back to it,
    // so stale entries need no clearing between partitions.
    logic           r_clr_busy;
    t_slot          r_clr_addr;

    logic           a_we;
    t_slot          a_waddr;
    logic [GW-1:0]  a_wdata;
    logic [GW-1:0]  a_rdata;
    t_slot          b_rdata;

    logic           r_s1_v;
    t_slot          r_s1_slot;
    logic           r_s1_last;

    logic           r_s2_v;
    t_slot          r_s2_slot;
    logic           r_s2_last;
    logic [GW-1:0]  r_s2_g;

    // Recent pair table writes (h1 newest, h2 older), not yet visible in the reads.
    logic           r_h1_v, r_h2_v;
    t_slot          r_h1_slot, r_h2_slot;
    logic [GW-1:0]  r_h1_g, r_h2_g;

    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;

    logic           fwd1, fwd2, mem_hit, hit, do_new;
    t_slot          key_eff;
    logic [GW-1:0]  hit_g, label;

    prl_ram #(.WIDTH(GW), .DEPTH(TABLE_DEPTH)) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (i_slot),
        .o_rdata (a_rdata)
    );

    prl_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ROWS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (do_new),
        .i_waddr (r_cnt[GW-1:0]),
        .i_wdata (r_s2_slot),
        .i_raddr (a_rdata),
        .o_rdata (b_rdata)
    );

    always_comb begin
        fwd1    = r_h1_v && (r_h1_slot == r_s2_slot);
        fwd2    = r_h2_v && (r_h2_slot == r_s2_slot);
        key_eff = (r_h1_v && (r_h1_g == r_s2_g)) ? r_h1_slot : b_rdata;
        mem_hit = (CW'(r_s2_g) < r_cnt) && (key_eff == r_s2_slot);
        hit     = fwd1 || fwd2 || mem_hit;
        hit_g   = fwd1 ? r_h1_g : (fwd2 ? r_h2_g : r_s2_g);
        do_new  = r_s2_v && !hit && (r_cnt < CW'(MAX_ROWS));
        if (hit) begin
            label = hit_g;
        end else if (do_new) begin
            label = r_cnt[GW-1:0];
        end else begin
            label = GW'(MAX_ROWS - 1);
        end
        n_cnt = r_cnt + CW'(do_new);
    end

    assign a_we    = r_clr_busy || do_new;
    assign a_waddr = r_clr_busy ? r_clr_addr : r_s2_slot;
    assign a_wdata = r_clr_busy ? '0 : r_cnt[GW-1:0];

    assign o_res_valid       = r_s2_v;
    assign o_res.new_label   = LABEL_W'(label);
    assign o_res.group_total = TOTAL_W'(n_cnt);
    assign o_res.end_mark    = r_s2_last;
    assign o_stat.clearing   = r_clr_busy;
    assign o_stat.inflight   = 2'(r_s1_v) + 2'(r_s2_v);

    always_ff @(posedge i_clk) begin
        r_s1_slot <= i_slot;
        r_s1_last <= i_last;
        r_s2_slot <= r_s1_slot;
        r_s2_last <= r_s1_last;
        r_s2_g    <= a_rdata;
        r_h1_slot <= r_s2_slot;
        r_h1_g    <= r_cnt[GW-1:0];
        r_h2_slot <= r_h1_slot;
        r_h2_g    <= r_h1_g;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_h1_v     <= 1'b0;
            r_h2_v     <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + SLOT_W'(1);
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            if (r_s2_v && r_s2_last) begin
                // partition ends: forget the write history and the group count
                r_h1_v <= 1'b0;
                r_h2_v <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_h1_v <= do_new;
                r_h2_v <= r_h1_v;
                r_cnt  <= n_cnt;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_ROWS))
        else $error("group counter above limit");

    a_no_beat_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !r_clr_busy)
        else $error("beat accepted during table clear");

    a_last_resets_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && r_s2_last) |=> (r_cnt == '0))
        else $error("counter not cleared after last row");

    a_fwd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> !(fwd1 && fwd2))
        else $error("slot written twice in one partition");
`endif

endmodule

`default_nettype wire

FILE: hdl/partition_refinement_labeler.sv
// Top level: stream ports, credit-based ready and the result queue.
`timescale 1ns / 1ps
`default_nettype none

// An accepted input beat passes core stages s1 and s2 and the result queue before its result beat is output.
// Throughput: one row per cycle while tready is high; the two-read lookup pipeline
//   with write forwarding sets this, and a 4-entry result queue absorbs output stalls.
// Reset: synchronous, active low. After reset all 4096 pair table entries are swept
//   to zero with tready low before the first row is taken.

module partition_refinement_labeler
    import prl_pkg::*;
#(
    parameter int MAX_ROWS = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // label_first, label_second
    input  wire logic                   i_s_axis_tlast,  // last_row
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,  // new_label, group_total
    output logic                        o_m_axis_tlast   // end_mark
);

    logic                in_beat;
    t_slot               slot;
    logic                res_valid;
    t_result             res;
    t_result             q_data;
    t_core_stat          stat;
    logic [QCNT_W-1:0]   q_count;
    logic [QCNT_W-1:0]   occupancy;

    // slot = label_first * 64 + label_second
    assign slot      = {i_s_axis_tdata[LABEL_W-1:0], i_s_axis_tdata[SLOT_W-1:LABEL_W]};
    assign occupancy = q_count + QCNT_W'(stat.inflight);
    assign o_s_axis_tready = !stat.clearing && (occupancy < QCNT_W'(QUEUE_DEPTH));
    assign in_beat   = i_s_axis_tvalid && o_s_axis_tready;

    prl_core #(.MAX_ROWS(MAX_ROWS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_beat),
        .i_slot      (slot),
        .i_last      (i_s_axis_tlast),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_stat      (stat)
    );

    prl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_pop   (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_m_axis_tdata = {
        (OUT_TDATA_W - LABEL_W - TOTAL_W)'(0), q_data.group_total, q_data.new_label
    };
    assign o_m_axis_tlast = q_data.end_mark;

endmodule

`default_nettype wire
